// ===== rtl/ndgag_pkg.sv =====
package ndgag_pkg;

	localparam int IDX_W       = 40;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int RANK_CFG_W  = 3;
	localparam int AXIS_CFG_W  = 2;
	localparam int DIM_CFG_W   = 11;
	localparam int NUM_DIM_CFG = 4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANK    = 3'd0,
		CFG_AXIS    = 3'd1,
		CFG_SCATTER = 3'd2,
		CFG_DIM_0   = 3'd3,
		CFG_DIM_1   = 3'd4,
		CFG_DIM_2   = 3'd5,
		CFG_DIM_3   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic last;
		logic unused;
	} stride_ctl_t;

	typedef struct packed {
		logic carry;
		logic top;
	} digit_stat_t;

	typedef struct packed {
		idx_t read_index;
		idx_t write_index;
		logic line_end;
		logic pass_end;
	} result_t;

endpackage

// ===== rtl/ndgag_stride_cell.sv =====
module ndgag_stride_cell #(
	parameter int DIM_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ndgag_pkg::stride_ctl_t ctl,
	input  ndgag_pkg::idx_t       stride_next,
	input  logic [DIM_W-1:0]      dim_next,
	output ndgag_pkg::idx_t       stride_q
);

	localparam int PROD_W = ndgag_pkg::IDX_W + DIM_W;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(stride_next) * PROD_W'(dim_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= '0;
		end else if (ctl.last) begin
			stride_q <= ndgag_pkg::idx_t'(1);
		end else if (ctl.unused) begin
			stride_q <= '0;
		end else begin
			stride_q <= prod[ndgag_pkg::IDX_W-1:0];
		end
	end

endmodule

// ===== rtl/ndgag_digit_cell.sv =====
module ndgag_digit_cell #(
	parameter int CNT_W = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   adv,
	input  logic                   carry_in,
	input  logic [CNT_W-1:0]       limit_load,
	input  ndgag_pkg::idx_t        stride_load,
	input  ndgag_pkg::idx_t        base_in,
	output ndgag_pkg::idx_t        base_out,
	output ndgag_pkg::digit_stat_t stat
);

	logic [CNT_W-1:0] digit_q;
	logic [CNT_W-1:0] limit_q;
	logic [CNT_W-1:0] digit_nx;
	logic [CNT_W-1:0] limit_nx;
	ndgag_pkg::idx_t  stride_q;
	ndgag_pkg::idx_t  base_q;
	ndgag_pkg::idx_t  base_inc;
	logic             at_limit;
	logic             incr;

	assign at_limit   = (digit_q == limit_q);
	assign incr       = carry_in & ~at_limit;
	assign base_inc   = base_q + stride_q;
	assign base_out   = incr ? base_inc : base_in;
	assign stat.carry = carry_in & at_limit;

	always_comb begin
		if (start) begin
			digit_nx = '0;
			limit_nx = limit_load;
		end else begin
			digit_nx = digit_q;
			limit_nx = limit_q;
			if (adv && carry_in) begin
				digit_nx = at_limit ? '0 : digit_q + 1'b1;
			end
		end
	end

	assign stat.top = (digit_nx == limit_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			limit_q <= '0;
		end else begin
			digit_q <= digit_nx;
			limit_q <= limit_nx;
		end
	end

	// prefix offset of this digit and all slower ones
	always_ff @(posedge clk) begin
		if (start) begin
			stride_q <= stride_load;
			base_q   <= '0;
		end else if (adv && carry_in) begin
			base_q <= base_out;
		end
	end

endmodule

// ===== rtl/nd_axis_gather_address_generator.sv =====
// Address generator for one axis pass over a row-major array of up to MAX_RANK dimensions.
// Each word taken on the input channel (restart=1, or a word after a pass end, starts a
// pass; others step) gives one read_index/write_index pair, one word per clock cycle when
// the output is not stalled. The odometer over the non-pass axes is a row of digit cells
// that each keep their own running offset, so a step costs one add and a carry through the
// row, with no multiplier in the stepping path. Strides come from a row of stride cells,
// one multiplier per axis, that recompute from the configuration registers continuously;
// after reset and after every configuration write the input stays not ready while that row
// settles. Two output registers let the block take a word while a result is still waiting.
module nd_axis_gather_address_generator #(
	parameter int MAX_RANK = 4,
	parameter int DIM_MAX  = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [ndgag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ndgag_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             restart,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ndgag_pkg::idx_t                  read_index,
	output ndgag_pkg::idx_t                  write_index,
	output logic                             line_end,
	output logic                             pass_end
);

	localparam int NCELL  = MAX_RANK - 1;
	localparam int DIM_W  = $clog2(DIM_MAX + 1);
	localparam int CNT_W  = $clog2(DIM_MAX);
	localparam int RANK_W = $clog2(MAX_RANK + 1);
	localparam int AX_W   = $clog2(MAX_RANK);
	localparam int SET_W  = $clog2(MAX_RANK + 1);
	localparam int RCW    = ndgag_pkg::RANK_CFG_W;
	localparam int ACW    = ndgag_pkg::AXIS_CFG_W;
	localparam int DCW    = ndgag_pkg::DIM_CFG_W;
	localparam int NDC    = ndgag_pkg::NUM_DIM_CFG;

	// configuration registers
	logic [RCW-1:0]   rank_cfg_q;
	logic [ACW-1:0]   axis_cfg_q;
	logic             scatter_cfg_q;
	logic [DCW-1:0]   dim_cfg_q [NDC];
	logic [SET_W-1:0] settle_q;

	logic [RANK_W-1:0] rank_c;
	logic [AX_W-1:0]   axis_c;
	logic [DIM_W-1:0]  dim_c [MAX_RANK];
	ndgag_pkg::idx_t   stride_q [MAX_RANK];

	// pass state
	logic             pass_done_q;
	logic [CNT_W-1:0] inner_q;
	logic [DIM_W-1:0] axis_len_q;
	ndgag_pkg::idx_t  stride_axis_q;
	ndgag_pkg::idx_t  strided_q;
	ndgag_pkg::idx_t  linear_q;

	logic             acc;
	logic             start;
	logic             adv;
	logic             inner_last;
	logic [CNT_W-1:0] inner_nx;
	logic [DIM_W-1:0] len_nx;
	ndgag_pkg::idx_t  strided_nx;
	ndgag_pkg::idx_t  linear_nx;
	logic             line_end_nx;
	logic             pass_end_nx;
	ndgag_pkg::idx_t  newbase;

	logic                   carry_v [NCELL+1];
	ndgag_pkg::idx_t        base_v  [NCELL+1];
	ndgag_pkg::digit_stat_t stat_v  [NCELL];
	logic [NCELL-1:0]       top_v;

	// output buffer
	ndgag_pkg::result_t res;
	ndgag_pkg::result_t ent0_q;
	ndgag_pkg::result_t ent1_q;
	logic [1:0]         cnt_q;
	logic               pop;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DCW-1:0] v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		if (int'(v) > DIM_MAX) begin
			return DIM_W'(DIM_MAX);
		end
		return DIM_W'(v);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_cfg_q    <= RCW'(2);
			axis_cfg_q    <= '0;
			scatter_cfg_q <= 1'b0;
			for (int i = 0; i < NDC; i++) begin
				dim_cfg_q[i] <= DCW'(1);
			end
		end else if (cfg_write) begin
			case (cfg_index)
				ndgag_pkg::CFG_RANK:    rank_cfg_q    <= cfg_data[RCW-1:0];
				ndgag_pkg::CFG_AXIS:    axis_cfg_q    <= cfg_data[ACW-1:0];
				ndgag_pkg::CFG_SCATTER: scatter_cfg_q <= cfg_data[0];
				ndgag_pkg::CFG_DIM_0:   dim_cfg_q[0]  <= cfg_data[DCW-1:0];
				ndgag_pkg::CFG_DIM_1:   dim_cfg_q[1]  <= cfg_data[DCW-1:0];
				ndgag_pkg::CFG_DIM_2:   dim_cfg_q[2]  <= cfg_data[DCW-1:0];
				ndgag_pkg::CFG_DIM_3:   dim_cfg_q[3]  <= cfg_data[DCW-1:0];
				default: ;
			endcase
		end
	end

	// hold the input off while the stride row settles after reset or a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SET_W'(MAX_RANK);
		end else if (cfg_write) begin
			settle_q <= SET_W'(MAX_RANK);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - 1'b1;
		end
	end

	always_comb begin
		if (int'(rank_cfg_q) < 2) begin
			rank_c = RANK_W'(2);
		end else if (int'(rank_cfg_q) > MAX_RANK) begin
			rank_c = RANK_W'(MAX_RANK);
		end else begin
			rank_c = RANK_W'(rank_cfg_q);
		end
		if (int'(axis_cfg_q) > int'(rank_c) - 2) begin
			axis_c = AX_W'(int'(rank_c) - 2);
		end else begin
			axis_c = AX_W'(axis_cfg_q);
		end
	end

	for (genvar d = 0; d < MAX_RANK; d++) begin : g_axis
		ndgag_pkg::stride_ctl_t ctl;
		ndgag_pkg::idx_t        s_next;
		logic [DIM_W-1:0]       d_next;

		if (d < NDC) begin : g_cfg
			assign dim_c[d] = clamp_dim(dim_cfg_q[d]);
		end else begin : g_one
			assign dim_c[d] = DIM_W'(1);
		end

		if (d < MAX_RANK - 1) begin : g_mid
			assign s_next = stride_q[d+1];
			assign d_next = dim_c[d+1];
		end else begin : g_end
			assign s_next = '0;
			assign d_next = '0;
		end

		assign ctl.last   = (int'(rank_c) == d + 1);
		assign ctl.unused = (int'(rank_c) < d + 1);

		ndgag_stride_cell #(
			.DIM_W(DIM_W)
		) u_stride (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.stride_next(s_next),
			.dim_next   (d_next),
			.stride_q   (stride_q[d])
		);
	end

	assign acc   = in_valid & in_ready;
	assign start = acc & (restart | pass_done_q);
	assign adv   = acc & ~(restart | pass_done_q);

	assign inner_last = ((DIM_W'(inner_q) + 1'b1) == axis_len_q);

	// carry runs from the fastest digit down, offset runs from the slowest up
	assign carry_v[NCELL] = inner_last;
	assign base_v[0]      = '0;

	for (genvar j = 0; j < NCELL; j++) begin : g_digit
		logic [AX_W-1:0]  ax_j;
		logic [CNT_W-1:0] lim_j;

		assign ax_j  = (AX_W'(j) < axis_c) ? AX_W'(j) : AX_W'(j + 1);
		assign lim_j = (j + 1 < int'(rank_c)) ? CNT_W'(dim_c[ax_j] - 1'b1) : '0;

		ndgag_digit_cell #(
			.CNT_W(CNT_W)
		) u_digit (
			.clk        (clk),
			.arst_n     (arst_n),
			.start      (start),
			.adv        (adv),
			.carry_in   (carry_v[j+1]),
			.limit_load (lim_j),
			.stride_load(stride_q[ax_j]),
			.base_in    (base_v[j]),
			.base_out   (base_v[j+1]),
			.stat       (stat_v[j])
		);

		assign carry_v[j] = stat_v[j].carry;
		assign top_v[j]   = stat_v[j].top;
	end

	assign newbase = base_v[NCELL];

	always_comb begin
		if (start) begin
			inner_nx   = '0;
			len_nx     = dim_c[axis_c];
			strided_nx = '0;
			linear_nx  = '0;
		end else begin
			len_nx     = axis_len_q;
			linear_nx  = linear_q + 1'b1;
			if (inner_last) begin
				inner_nx   = '0;
				strided_nx = newbase;
			end else begin
				inner_nx   = inner_q + 1'b1;
				strided_nx = strided_q + stride_axis_q;
			end
		end
		line_end_nx = ((DIM_W'(inner_nx) + 1'b1) == len_nx);
		pass_end_nx = line_end_nx & (&top_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_done_q <= 1'b1;
			inner_q     <= '0;
			axis_len_q  <= '0;
		end else if (acc) begin
			pass_done_q <= pass_end_nx;
			inner_q     <= inner_nx;
			axis_len_q  <= len_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			stride_axis_q <= stride_q[axis_c];
		end
		if (acc) begin
			strided_q <= strided_nx;
			linear_q  <= linear_nx;
		end
	end

	assign res.read_index  = scatter_cfg_q ? linear_nx : strided_nx;
	assign res.write_index = scatter_cfg_q ? strided_nx : linear_nx;
	assign res.line_end    = line_end_nx;
	assign res.pass_end    = pass_end_nx;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid & out_ready;
	assign in_ready  = (settle_q == '0) && (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(acc) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: begin
				if (acc) begin
					ent0_q <= res;
				end
			end
			2'd1: begin
				if (acc && pop) begin
					ent0_q <= res;
				end else if (acc) begin
					ent1_q <= res;
				end
			end
			2'd2: begin
				if (pop) begin
					ent0_q <= ent1_q;
				end
			end
			default: ;
		endcase
	end

	assign read_index  = ent0_q.read_index;
	assign write_index = ent0_q.write_index;
	assign line_end    = ent0_q.line_end;
	assign pass_end    = ent0_q.pass_end;

endmodule

// ===== rtl/ndgag_checker.sv =====
module ndgag_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_write,
	input logic [ndgag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [ndgag_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             restart,
	input logic                             out_valid,
	input logic                             out_ready,
	input ndgag_pkg::idx_t                  read_index,
	input ndgag_pkg::idx_t                  write_index,
	input logic                             line_end,
	input logic                             pass_end
);

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_index) &&
		$stable(write_index) && $stable(line_end) && $stable(pass_end))
		else $error("output word changed while stalled");

	// the end of a pass is always the end of a line
	a_pass_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pass_end |-> line_end)
		else $error("pass_end without line_end");

	// strides rebuild after a register write
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> !in_ready)
		else $error("input taken right after a register write");

	// no word appears without one taken
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !(in_valid && in_ready) |=> !out_valid)
		else $error("output word without input word");

endmodule

bind nd_axis_gather_address_generator ndgag_checker u_ndgag_checker (.*);
